// ===== rtl/dsss_pkg.sv =====
`default_nettype none

package dsss_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYL_W = 13;
	localparam int MOVE_W = 18;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	// sort key: cylinder above queue position, so equal cylinders still order strictly
	localparam int KEY_W = CYL_W + IDX_W;

	localparam logic [CYL_W-1:0] DISK_MAX_RESET = 13'd4999;
	localparam logic [CYL_W-1:0] EDGE_LOW = '0;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	typedef struct packed {
		logic op;
		logic [CYL_W-1:0] cylinder;
		logic [CYL_W-1:0] head_start;
		logic sweep_up;
		logic use_scan;
	} req_t;

	typedef struct packed {
		logic [CYL_W-1:0] served_cylinder;
		logic is_edge_visit;
		logic [MOVE_W-1:0] total_movement;
		logic last;
	} res_t;

	typedef struct packed {
		logic [CYL_W-1:0] head;
		logic sweep_up;
		logic phase;
		logic prev_valid;
		logic [KEY_W-1:0] prev_key;
		logic best_valid;
		logic [KEY_W-1:0] best_key;
	} scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dsss_store.sv =====
`default_nettype none

module dsss_store (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [dsss_pkg::CYL_W-1:0] wr_data,
	input wire logic [dsss_pkg::IDX_W-1:0] rd_idx,
	output logic [dsss_pkg::CYL_W-1:0] rd_data,
	output logic [dsss_pkg::CNT_W-1:0] count
);

	logic [dsss_pkg::CYL_W-1:0] mem_q [dsss_pkg::QUEUE_DEPTH];
	logic [dsss_pkg::CNT_W-1:0] count_q;
	logic full;

	assign full = (count_q == dsss_pkg::CNT_W'(dsss_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[count_q[dsss_pkg::IDX_W-1:0]] <= wr_data;
		end
	end

	// a load into a full queue is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en && !full) begin
			count_q <= count_q + dsss_pkg::CNT_W'(1);
		end
	end

	assign rd_data = mem_q[rd_idx];
	assign count = count_q;

endmodule

`default_nettype wire

// ===== rtl/dsss_scan.sv =====
`default_nettype none

module dsss_scan (
	input wire dsss_pkg::scan_ctl_t ctl,
	input wire logic [dsss_pkg::CYL_W-1:0] entry,
	input wire logic [dsss_pkg::IDX_W-1:0] idx,
	output logic take,
	output logic [dsss_pkg::KEY_W-1:0] key
);

	logic ge_head;
	logic le_head;
	logic in_range;
	logic ascending;
	logic after_prev;
	logic beats_best;

	always_comb begin
		key = {entry, idx};
		ge_head = (entry >= ctl.head);
		le_head = (entry <= ctl.head);
		// first sweep takes the head's own cylinder, the return sweep the other side
		if (ctl.sweep_up) begin
			in_range = ctl.phase ? !ge_head : ge_head;
		end else begin
			in_range = ctl.phase ? !le_head : le_head;
		end
		ascending = ctl.sweep_up ^ ctl.phase;
		if (ascending) begin
			after_prev = !ctl.prev_valid || (key > ctl.prev_key);
			beats_best = !ctl.best_valid || (key < ctl.best_key);
		end else begin
			after_prev = !ctl.prev_valid || (key < ctl.prev_key);
			beats_best = !ctl.best_valid || (key > ctl.best_key);
		end
		take = in_range && after_prev && beats_best;
	end

endmodule

`default_nettype wire

// ===== rtl/disk_scan_seek_scheduler.sv =====
// load item: the block is ready again in the next cycle
// fcfs run over n queued requests: one result per cycle when not stalled
// scan run: the single compare unit walks the whole queue once for every served request and
// once more to close each sweep
// arst_n clears the queue count, the sequencer and the output item; disk_max_cylinder
// resets to 4999 and the store contents stay undefined until loaded
`default_nettype none

module disk_scan_seek_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire dsss_pkg::req_t req,
	output logic res_valid,
	input wire logic res_ready,
	output dsss_pkg::res_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [dsss_pkg::CYL_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FCFS,
		S_SEARCH,
		S_PICK,
		S_FLUSH
	} state_t;

	state_t state_q;
	logic [dsss_pkg::CYL_W-1:0] max_q;
	logic [dsss_pkg::CYL_W-1:0] head_q;
	logic up_q;
	logic phase_q;
	logic [dsss_pkg::IDX_W-1:0] idx_q;
	logic prev_valid_q;
	logic [dsss_pkg::KEY_W-1:0] prev_key_q;
	logic best_valid_q;
	logic [dsss_pkg::KEY_W-1:0] best_key_q;
	logic [dsss_pkg::CYL_W-1:0] pos_q;
	logic [dsss_pkg::MOVE_W-1:0] total_q;
	logic pend_valid_q;
	logic [dsss_pkg::CYL_W-1:0] pend_cyl_q;
	logic pend_edge_q;
	logic [dsss_pkg::MOVE_W-1:0] pend_total_q;
	logic res_valid_q;
	dsss_pkg::res_t res_q;

	logic [dsss_pkg::CYL_W-1:0] entry;
	logic [dsss_pkg::CNT_W-1:0] count;
	logic load_en;
	logic [dsss_pkg::CYL_W-1:0] cyl_clamp;
	logic [dsss_pkg::CYL_W-1:0] head_clamp;
	dsss_pkg::scan_ctl_t scan_ctl;
	logic take;
	logic [dsss_pkg::KEY_W-1:0] key;
	logic last_idx;
	logic slot_free;
	logic emit_ok;
	logic emit_fire;
	logic res_push;
	logic [dsss_pkg::CYL_W-1:0] emit_cyl;
	logic emit_edge;
	logic [dsss_pkg::CYL_W-1:0] step_dist;
	logic [dsss_pkg::MOVE_W-1:0] next_total;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign load_en = req_valid && req_ready && (req.op == dsss_pkg::OP_LOAD);
	assign cyl_clamp = (req.cylinder > max_q) ? max_q : req.cylinder;
	assign head_clamp = (req.head_start > max_q) ? max_q : req.head_start;

	dsss_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(load_en),
		.wr_data(cyl_clamp),
		.rd_idx(idx_q),
		.rd_data(entry),
		.count(count)
	);

	always_comb begin
		scan_ctl.head = head_q;
		scan_ctl.sweep_up = up_q;
		scan_ctl.phase = phase_q;
		scan_ctl.prev_valid = prev_valid_q;
		scan_ctl.prev_key = prev_key_q;
		scan_ctl.best_valid = best_valid_q;
		scan_ctl.best_key = best_key_q;
	end

	dsss_scan u_scan (
		.ctl(scan_ctl),
		.entry(entry),
		.idx(idx_q),
		.take(take),
		.key(key)
	);

	assign last_idx = (dsss_pkg::CNT_W'(idx_q) == (count - dsss_pkg::CNT_W'(1)));
	assign slot_free = !res_valid_q || res_ready;
	// the held result only moves out once the next one exists, so last is known
	assign emit_ok = !pend_valid_q || slot_free;

	always_comb begin
		emit_cyl = entry;
		emit_edge = 1'b0;
		if (state_q == S_PICK) begin
			if (best_valid_q) begin
				emit_cyl = best_key_q[dsss_pkg::KEY_W-1:dsss_pkg::IDX_W];
			end else begin
				emit_cyl = up_q ? max_q : dsss_pkg::EDGE_LOW;
				emit_edge = 1'b1;
			end
		end
		emit_fire = emit_ok && ((state_q == S_FCFS) ||
			((state_q == S_PICK) && (best_valid_q || !phase_q)));
		step_dist = (pos_q >= emit_cyl) ? (pos_q - emit_cyl) : (emit_cyl - pos_q);
		next_total = total_q + dsss_pkg::MOVE_W'(step_dist);
		res_push = ((state_q == S_FLUSH) && slot_free) || (emit_fire && pend_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q <= dsss_pkg::DISK_MAX_RESET;
			head_q <= '0;
			up_q <= 1'b0;
			phase_q <= 1'b0;
			idx_q <= '0;
			prev_valid_q <= 1'b0;
			prev_key_q <= '0;
			best_valid_q <= 1'b0;
			best_key_q <= '0;
			pos_q <= '0;
			total_q <= '0;
			pend_valid_q <= 1'b0;
			pend_cyl_q <= '0;
			pend_edge_q <= 1'b0;
			pend_total_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (res_push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid && (req.op == dsss_pkg::OP_RUN)) begin
						head_q <= head_clamp;
						pos_q <= head_clamp;
						total_q <= '0;
						up_q <= req.sweep_up;
						phase_q <= 1'b0;
						idx_q <= '0;
						prev_valid_q <= 1'b0;
						best_valid_q <= 1'b0;
						pend_valid_q <= 1'b0;
						if (req.use_scan) begin
							state_q <= (count == '0) ? S_PICK : S_SEARCH;
						end else if (count != '0) begin
							state_q <= S_FCFS;
						end
					end
				end
				S_FCFS: begin
					if (emit_ok) begin
						idx_q <= idx_q + dsss_pkg::IDX_W'(1);
						if (last_idx) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_SEARCH: begin
					if (take) begin
						best_valid_q <= 1'b1;
						best_key_q <= key;
					end
					if (last_idx) begin
						idx_q <= '0;
						state_q <= S_PICK;
					end else begin
						idx_q <= idx_q + dsss_pkg::IDX_W'(1);
					end
				end
				S_PICK: begin
					if (best_valid_q) begin
						if (emit_ok) begin
							prev_valid_q <= 1'b1;
							prev_key_q <= best_key_q;
							best_valid_q <= 1'b0;
							idx_q <= '0;
							state_q <= S_SEARCH;
						end
					end else if (!phase_q) begin
						// first sweep exhausted: go to the edge and turn around
						if (emit_ok) begin
							phase_q <= 1'b1;
							prev_valid_q <= 1'b0;
							idx_q <= '0;
							if (count != '0) begin
								state_q <= S_SEARCH;
							end
						end
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						res_q <= '{pend_cyl_q, pend_edge_q, pend_total_q, 1'b1};
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (emit_fire) begin
				pos_q <= emit_cyl;
				total_q <= next_total;
				if (pend_valid_q) begin
					res_q <= '{pend_cyl_q, pend_edge_q, pend_total_q, 1'b0};
				end
				pend_valid_q <= 1'b1;
				pend_cyl_q <= emit_cyl;
				pend_edge_q <= emit_edge;
				pend_total_q <= next_total;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dsss_checker.sv =====
`default_nettype none

module dsss_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire dsss_pkg::req_t req,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire dsss_pkg::res_t res,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [dsss_pkg::CYL_W-1:0] cfg_data
);

	logic [dsss_pkg::CYL_W-1:0] max_q;
	logic in_run_q;
	logic [dsss_pkg::MOVE_W-1:0] prev_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= dsss_pkg::DISK_MAX_RESET;
			in_run_q <= 1'b0;
			prev_total_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				in_run_q <= !res.last;
				prev_total_q <= res.total_movement;
			end
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// a result that is not the last one means the run is still going
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> !req_ready)
		else $error("new item taken in the middle of a run");

	a_edge_cyl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_edge_visit && (res.served_cylinder != dsss_pkg::EDGE_LOW)
		|-> res.served_cylinder == max_q)
		else $error("edge visit is neither cylinder zero nor the disk limit");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && in_run_q |-> res.total_movement >= prev_total_q)
		else $error("head movement total went down within a run");

endmodule

bind disk_scan_seek_scheduler dsss_checker u_dsss_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req(req),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res(res),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_data(cfg_data)
);

`default_nettype wire
